// ===== rtl/running_interval_concurrency_core_defines.svh =====
// Assertion macros shared by the interval concurrency RTL.
`ifndef RUNNING_INTERVAL_CONCURRENCY_CORE_DEFINES_SVH
`define RUNNING_INTERVAL_CONCURRENCY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ric_pkg.sv =====
// Package: shared types and constants for the interval concurrency block.
package ric_pkg;

  localparam int IN_TIME_W = 64;
  localparam int CONC_W    = 7;
  localparam logic [CONC_W-1:0] CONC_MAX = 7'd127;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_INSERT,
    S_PUBLISH
  } state_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic insert;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_order;
    logic sweep_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/ric_in_if.sv =====
// Interface: input event channel (valid/ready plus event word).
interface ric_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ric_pkg::IN_TIME_W-1:0] start_time;
  logic signed [ric_pkg::IN_TIME_W-1:0] end_time;
  logic                               last_in_block;

  modport source (output valid, output start_time, output end_time,
                  output last_in_block, input ready);
  modport sink   (input valid, input start_time, input end_time,
                  input last_in_block, output ready);
endinterface

// ===== rtl/ric_out_if.sv =====
// Interface: result channel (valid/ready plus result word).
interface ric_out_if;
  logic                        valid;
  logic                        ready;
  logic [ric_pkg::CONC_W-1:0]  concurrency;
  ric_pkg::status_t            status;

  modport source (output valid, output concurrency, output status, input ready);
  modport sink   (input valid, input concurrency, input status, output ready);
endinterface

// ===== rtl/ric_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ric_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/ric_dp.sv =====
// Datapath: end-time store, compaction sweep, insert, result register.
`include "running_interval_concurrency_core_defines.svh"
module ric_dp #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ric_pkg::dp_cmd_t             cmd,
  output ric_pkg::dp_sts_t             sts,
  input  logic signed [TIME_BITS-1:0]  in_start,
  input  logic signed [TIME_BITS-1:0]  in_end,
  input  logic                         in_last,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [ric_pkg::CONC_W-1:0]   out_concurrency,
  output ric_pkg::status_t             out_status
);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ric_pkg::CONC_W) ? CW : ric_pkg::CONC_W;

  logic signed [TIME_BITS-1:0] s_r, e_r;
  logic                        last_r;
  logic [CW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]               wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  ric_pkg::status_t            status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ric_pkg::CONC_W-1:0]  out_conc_r;
  ric_pkg::status_t            out_status_r;

  logic                        ram_we;
  logic [TIME_BITS-1:0]        ram_wdata, ram_rdata;
  logic                        bad_order, rd_issue, keep, sweep_wr, ins_wr, has_room, nonzero;
  logic [ric_pkg::CONC_W-1:0]  conc_sat;

  ric_ram #(.WIDTH(TIME_BITS), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (rd_issue),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    bad_order = s_r > e_r;
    nonzero   = e_r != s_r;
    has_room  = wr_idx_r != CW'(CAPACITY);
    rd_issue  = cmd.sweep && (rd_idx_r != count_r);
    // survivors are ends strictly after the new start
    keep      = $signed(ram_rdata) > s_r;
    sweep_wr  = cmd.sweep && rd_pend_r && keep;
    ins_wr    = cmd.insert && !bad_order && nonzero && has_room;
    ram_we    = sweep_wr || ins_wr;
    ram_wdata = ins_wr ? e_r : ram_rdata;

    sts.bad_order  = bad_order;
    sts.sweep_done = (rd_idx_r == count_r) && !rd_pend_r;
    sts.out_busy   = out_valid_r && !out_ready;

    conc_sat = (CMPW'(count_r) > CMPW'(ric_pkg::CONC_MAX)) ? ric_pkg::CONC_MAX
                                                            : ric_pkg::CONC_W'(count_r);

    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    rd_pend_nxt   = 1'b0;
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
    end
    if (rd_issue) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
    end
    if (cmd.sweep) begin
      rd_pend_nxt = rd_issue;
    end
    if (sweep_wr) begin
      wr_idx_nxt = wr_idx_r + CW'(1);
    end
    if (cmd.insert) begin
      if (bad_order) begin
        status_nxt = ric_pkg::ST_ORDER;
      end else if (ins_wr) begin
        count_nxt  = wr_idx_r + CW'(1);
        status_nxt = ric_pkg::ST_OK;
      end else begin
        count_nxt  = wr_idx_r;
        status_nxt = (nonzero && !has_room) ? ric_pkg::ST_FULL : ric_pkg::ST_OK;
      end
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
      if (last_r) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      status_r    <= ric_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r    <= in_start;
      e_r    <= in_end;
      last_r <= in_last;
    end
    if (cmd.publish) begin
      out_conc_r   <= conc_sat;
      out_status_r <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_concurrency = out_conc_r;
  assign out_status      = out_status_r;

  // compaction write pointer never overtakes the read pointer
  `RIC_ASSERT_NOW(a_wr_behind_rd, cmd.sweep, wr_idx_r <= rd_idx_r, "write index passed read index")
  // a write during the sweep never lands on the address being read
  `RIC_ASSERT_NOW(a_no_rw_clash, sweep_wr && rd_issue, wr_idx_r != rd_idx_r, "sweep write hit read address")
  // last word of a block leaves the store empty
  `RIC_ASSERT_NXT(a_block_clear, cmd.publish && last_r, count_r == '0, "store not cleared at block end")
endmodule

// ===== rtl/ric_ctrl.sv =====
// Controller: sequences load, sweep, insert and publish for one word.
`include "running_interval_concurrency_core_defines.svh"
module ric_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ric_pkg::dp_sts_t sts,
  output ric_pkg::dp_cmd_t cmd
);
  ric_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ric_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ric_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ric_pkg::S_SWEEP;
        end
      end
      ric_pkg::S_SWEEP: begin
        if (sts.bad_order) begin
          state_nxt = ric_pkg::S_INSERT;
        end else begin
          cmd.sweep = 1'b1;
          if (sts.sweep_done) begin
            state_nxt = ric_pkg::S_INSERT;
          end
        end
      end
      ric_pkg::S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ric_pkg::S_PUBLISH;
      end
      ric_pkg::S_PUBLISH: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ric_pkg::S_IDLE;
        end
      end
      default: state_nxt = ric_pkg::S_IDLE;
    endcase
  end

  // an accepted word closes the input until its result is published
  `RIC_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready && state_r == ric_pkg::S_SWEEP, "input reopened early")
endmodule

// ===== rtl/running_interval_concurrency_core.sv =====
// Top level: sweep-line running interval concurrency counter.
//
// Usage:
//  in_ch  : event words (start_time, end_time, last_in_block), valid/ready.
//           Times use the low TIME_BITS bits, compared as signed values.
//  out_ch : one result word per event (concurrency, status), valid/ready.
//  Status: ok, start after end (store untouched), or store full (end dropped).
//  Each accepted word runs load, sweep, insert and publish, and out_ch.valid
//  is raised from the output register once published. The sweep reads the
//  end store one entry per cycle through its single read port and compacts
//  survivors in place, so its length grows with the number of ends held; a
//  start-after-end word skips the sweep. A new word is taken only after the
//  last one is published.
//  The result sits in an output register; in_ch.ready returns while it waits,
//  so the next word is taken and worked on. If out_ch stalls, the block holds
//  in its publish step until the register frees up.
//  Reset (rst_n low, synchronous): the store is empty via a zero fill count,
//  no clearing pass is run. last_in_block empties the store after its word.
module running_interval_concurrency_core #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 64
) (
  input logic       clk,
  input logic       rst_n,
  ric_in_if.sink    in_ch,
  ric_out_if.source out_ch
);
  ric_pkg::dp_cmd_t cmd;
  ric_pkg::dp_sts_t sts;

  ric_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // only the low TIME_BITS bits of each timestamp take part
  ric_dp #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_start        (in_ch.start_time[TIME_BITS-1:0]),
    .in_end          (in_ch.end_time[TIME_BITS-1:0]),
    .in_last         (in_ch.last_in_block),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_concurrency (out_ch.concurrency),
    .out_status      (out_ch.status)
  );
endmodule
